### rtl/core/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared constants and types for the byte-streaming SHA-1 digest block.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [6:0] LAST_ROUND = 7'd79;

  // controller to datapath
  typedef struct packed {
    logic       put_byte;    // write byte into block buffer
    logic       pad_mark;    // write 0x80 at current position and clear the tail
    logic       clear_buf;   // zero whole buffer
    logic       put_len;     // write bit length into words 14 and 15
    logic       start_blk;   // load working vars from chaining value
    logic       do_round;    // one compression round
    logic       finish_blk;  // add working vars into chaining value
    logic       reinit;      // back to reset values
  } sha1_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       block_full;  // byte count at a 64-byte boundary
    logic       pos_gt55;    // padding position at or past the length field start
    logic       last_round;
  } sha1_stat_t;

endpackage

### rtl/core/sha1_datapath.sv
// ----------------------------------------------------------------------------
// sha1_datapath
// Block buffer, rolling schedule, working variables, chaining value, length.
// ----------------------------------------------------------------------------
module sha1_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1_pkg::sha1_cmd_t cmd,
  input  logic [7:0]          byte_in,
  output sha1_pkg::sha1_stat_t stat,
  output logic [159:0]        digest
);

  logic [31:0] w_r [16];
  logic [31:0] h_r [5];
  logic [31:0] v_r [5];
  logic [63:0] cnt_r;
  logic [6:0]  rnd_r;

  logic [5:0]  pos;
  logic [3:0]  widx;
  logic [4:0]  shamt;
  logic [7:0]  bval;
  logic [31:0] bword;
  logic [31:0] wcur, wsch, wnew, f, k, tmp;
  logic [63:0] bits;
  logic [3:0]  t3, t8, t14;

  assign pos   = cnt_r[5:0];
  assign widx  = pos[5:2];
  assign shamt = {~pos[1:0], 3'b000};
  assign bval  = cmd.pad_mark ? sha1_pkg::PAD_MARK : byte_in;
  assign bword = {24'd0, bval} << shamt;
  assign bits  = {cnt_r[60:0], 3'b000};

  assign t3  = rnd_r[3:0] - 4'd3;
  assign t8  = rnd_r[3:0] - 4'd8;
  assign t14 = rnd_r[3:0] - 4'd14;
  assign wcur = w_r[rnd_r[3:0]];
  assign wsch = w_r[t3] ^ w_r[t8] ^ w_r[t14] ^ wcur;
  assign wnew = (rnd_r < 7'd16) ? wcur : {wsch[30:0], wsch[31]};

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (v_r[1] & v_r[2]) | (~v_r[1] & v_r[3]);
      k = sha1_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      f = v_r[1] ^ v_r[2] ^ v_r[3];
      k = sha1_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      f = (v_r[1] & v_r[2]) | (v_r[1] & v_r[3]) | (v_r[2] & v_r[3]);
      k = sha1_pkg::K2;
    end else begin
      f = v_r[1] ^ v_r[2] ^ v_r[3];
      k = sha1_pkg::K3;
    end
  end

  assign tmp = {v_r[0][26:0], v_r[0][31:27]} + f + v_r[4] + wnew + k;

  assign stat.block_full = (pos == 6'd0) && cmd.put_byte == 1'b0;
  assign stat.pos_gt55   = (pos > 6'd55);
  assign stat.last_round = (rnd_r == sha1_pkg::LAST_ROUND);
  assign digest = {h_r[4], h_r[3], h_r[2], h_r[1], h_r[0]};

  // schedule / block buffer
  always_ff @(posedge clk) begin
    if (cmd.put_byte || cmd.pad_mark) begin
      if (pos[1:0] == 2'd0) w_r[widx] <= bword;
      else                  w_r[widx] <= w_r[widx] | bword;
      if (cmd.pad_mark) begin
        for (int i = 0; i < 16; i++) begin
          if (4'(i) > widx) w_r[i] <= '0;
        end
      end
    end else if (cmd.clear_buf) begin
      for (int i = 0; i < 16; i++) w_r[i] <= '0;
    end else if (cmd.put_len) begin
      w_r[14] <= bits[63:32];
      w_r[15] <= bits[31:0];
    end else if (cmd.do_round && rnd_r >= 7'd16) begin
      w_r[rnd_r[3:0]] <= wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      h_r[0] <= sha1_pkg::H0_INIT;
      h_r[1] <= sha1_pkg::H1_INIT;
      h_r[2] <= sha1_pkg::H2_INIT;
      h_r[3] <= sha1_pkg::H3_INIT;
      h_r[4] <= sha1_pkg::H4_INIT;
      for (int i = 0; i < 5; i++) v_r[i] <= '0;
      cnt_r <= '0;
      rnd_r <= '0;
    end else begin
      if (cmd.put_byte) cnt_r <= cnt_r + 64'd1;
      if (cmd.start_blk) begin
        for (int i = 0; i < 5; i++) v_r[i] <= h_r[i];
        rnd_r <= '0;
      end else if (cmd.do_round) begin
        v_r[0] <= tmp;
        v_r[1] <= v_r[0];
        v_r[2] <= {v_r[1][1:0], v_r[1][31:2]};
        v_r[3] <= v_r[2];
        v_r[4] <= v_r[3];
        rnd_r  <= stat.last_round ? 7'd0 : rnd_r + 7'd1;
      end
      if (cmd.finish_blk) begin
        for (int i = 0; i < 5; i++) h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

endmodule

### rtl/core/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: byte intake, block compression, padding and digest hand-off.
// ----------------------------------------------------------------------------
module sha1_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 in_present,
  input  logic                 in_last,
  input  logic                 out_busy,
  input  sha1_pkg::sha1_stat_t stat,
  output sha1_pkg::sha1_cmd_t  cmd,
  output logic                 in_ready,
  output logic                 out_load
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_START  = 4'd2;
  localparam logic [3:0] ST_ROUND  = 4'd3;
  localparam logic [3:0] ST_FIN    = 4'd4;
  localparam logic [3:0] ST_PAD    = 4'd5;
  localparam logic [3:0] ST_PADCHK = 4'd6;
  localparam logic [3:0] ST_CLEAR  = 4'd7;
  localparam logic [3:0] ST_LEN    = 4'd8;
  localparam logic [3:0] ST_EMIT   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       last_r, last_nxt;   // pending last beat
  logic       took_r, took_nxt;   // beat carried a byte
  logic       padblk_r, padblk_nxt; // block in flight is a padding block
  logic       final_r, final_nxt; // block in flight carries the length

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    last_nxt   = last_r;
    took_nxt   = took_r;
    padblk_nxt = padblk_r;
    final_nxt  = final_r;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.put_byte = in_present;
          last_nxt     = in_last;
          took_nxt     = in_present;
          padblk_nxt   = 1'b0;
          final_nxt    = 1'b0;
          if (in_present || in_last) state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // count wrapped to a block boundary after the last byte write
        if (stat.block_full && took_r) state_nxt = ST_START;
        else if (last_r)               state_nxt = ST_PAD;
        else                           state_nxt = ST_IDLE;
        // padding path reached without a full block only when not just filled
      end
      ST_START: begin
        cmd.start_blk = 1'b1;
        state_nxt     = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.do_round = 1'b1;
        if (stat.last_round) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish_blk = 1'b1;
        if (final_r) begin
          state_nxt = ST_EMIT;
        end else if (padblk_r) begin
          state_nxt = ST_CLEAR;
        end else begin
          padblk_nxt = 1'b1;
          state_nxt  = last_r ? ST_PAD : ST_IDLE;
          if (!last_r) padblk_nxt = 1'b0;
        end
      end
      ST_PAD: begin
        cmd.pad_mark = 1'b1;
        state_nxt    = ST_PADCHK;
      end
      ST_PADCHK: begin
        if (stat.pos_gt55) begin
          padblk_nxt = 1'b1;
          state_nxt  = ST_START;
        end else begin
          state_nxt = ST_LEN;
        end
      end
      ST_CLEAR: begin
        cmd.clear_buf = 1'b1;
        state_nxt     = ST_LEN;
      end
      ST_LEN: begin
        cmd.put_len = 1'b1;
        final_nxt   = 1'b1;
        state_nxt   = ST_START;
      end
      ST_EMIT: begin
        if (!out_busy) begin
          out_load   = 1'b1;
          cmd.reinit = 1'b1;
          last_nxt   = 1'b0;
          padblk_nxt = 1'b0;
          final_nxt  = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      last_r   <= 1'b0;
      took_r   <= 1'b0;
      padblk_r <= 1'b0;
      final_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      last_r   <= last_nxt;
      took_r   <= took_nxt;
      padblk_r <= padblk_nxt;
      final_r  <= final_nxt;
    end
  end

endmodule

### rtl/core/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest
// Byte-streaming SHA-1: pads on the last beat and returns the 160-bit digest.
// ----------------------------------------------------------------------------
// per byte: ST_IDLE then ST_CHECK; a byte closing a 64-byte block also runs
//   ST_START, the 80-round compression (one round per cycle) and ST_FIN
// last beat: one or two padded blocks are compressed before the digest
// intake: a new beat is accepted only in ST_IDLE, once the previous one
//   and any block it closed are fully processed
// reset: synchronous active-low rst_n restores the initial hash and clears
//   the length; the output register is emptied
module sha1_message_digest (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic         s_axis_tuser,  // byte_present
  input  logic         s_axis_tlast,  // last_item
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata   // digest_word0 .. digest_word4, low first
);

  sha1_pkg::sha1_cmd_t  cmd;
  sha1_pkg::sha1_stat_t stat;
  logic [159:0] digest;
  logic         in_fire, out_load;
  logic         ovalid_r;
  logic [159:0] odata_r;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_present (s_axis_tuser),
    .in_last    (s_axis_tlast),
    .out_busy   (ovalid_r && !m_axis_tready),
    .stat       (stat),
    .cmd        (cmd),
    .in_ready   (s_axis_tready),
    .out_load   (out_load)
  );

  sha1_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .byte_in (s_axis_tdata),
    .stat    (stat),
    .digest  (digest)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (out_load) begin
      ovalid_r <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) odata_r <= digest;
  end

  assign m_axis_tvalid = ovalid_r;
  assign m_axis_tdata  = odata_r;

endmodule
